### rtl/core/jtdk_pkg.sv
package jtdk_pkg;

   // Register file geometry
   localparam int CSR_WIDTH     = 10;
   localparam int CSR_IDX_WIDTH = 3;
   localparam int THRESH_WIDTH  = 7;
   localparam int MODE_WIDTH    = 3;

   // Percent scale and divider geometry
   localparam int PCT_FULL      = 100;
   localparam int QUOT_BITS     = 7;
   localparam int STEP_WIDTH    = 3;
   localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(QUOT_BITS - 1);

   // Register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_X_ORIGIN  = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_Y_ORIGIN  = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_AXIS_MIN  = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_AXIS_MAX  = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_THRESHOLD = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MODE      = 3'd5;

   // Operating modes
   localparam logic [MODE_WIDTH-1:0] MODE_MOUSE    = 3'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_SCROLL   = 3'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_WASD     = 3'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_USER     = 3'd3;
   localparam logic [MODE_WIDTH-1:0] MODE_JOYSTICK = 3'd4;

   // Direction actions
   localparam logic [2:0] ACT_NONE         = 3'd0;
   localparam logic [2:0] ACT_PRESS_LOW    = 3'd1;
   localparam logic [2:0] ACT_RELEASE_LOW  = 3'd2;
   localparam logic [2:0] ACT_PRESS_HIGH   = 3'd3;
   localparam logic [2:0] ACT_RELEASE_HIGH = 3'd4;

   // Key families reported with the actions
   localparam logic [1:0] KEYS_WHEEL = 2'd0;
   localparam logic [1:0] KEYS_WASD  = 2'd1;
   localparam logic [1:0] KEYS_USER  = 2'd2;

   // Reset values of the registers
   localparam logic [CSR_WIDTH-1:0]    ORIGIN_RESET    = 10'd512;
   localparam logic [CSR_WIDTH-1:0]    AXIS_MIN_RESET  = 10'd0;
   localparam logic [CSR_WIDTH-1:0]    AXIS_MAX_RESET  = 10'd1023;
   localparam logic [THRESH_WIDTH-1:0] THRESHOLD_RESET = 7'd50;

   typedef struct packed {
      logic [CSR_WIDTH-1:0]    x_origin;
      logic [CSR_WIDTH-1:0]    y_origin;
      logic [CSR_WIDTH-1:0]    axis_min;
      logic [CSR_WIDTH-1:0]    axis_max;
      logic [THRESH_WIDTH-1:0] threshold;
      logic [MODE_WIDTH-1:0]   mode;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIVIDE,
      ST_STORE,
      ST_PUBLISH
   } state_type;

   typedef struct packed {
      logic                  capture;
      logic                  setup;
      logic                  div_step;
      logic [STEP_WIDTH-1:0] step_idx;
      logic                  store;
      logic                  publish;
      logic                  axis;    // 0 x, 1 y
   } cmd_type;

   typedef struct packed {
      logic bypass;
      logic out_busy;
   } status_type;

   typedef struct packed {
      logic [2:0] action;
      logic       low;
      logic       high;
   } evt_type;

endpackage

### rtl/core/jtdk_ctrl.sv
module jtdk_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  jtdk_pkg::status_type   status,
   output jtdk_pkg::cmd_type      cmd
);
   import jtdk_pkg::*;

   state_type             state_ff, state_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic                  axis_ff, axis_in;

   // State, step counter and axis select
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= LAST_STEP;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         axis_ff  <= axis_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      axis_in      = axis_ff;
      cmd          = '0;
      cmd.axis     = axis_ff;
      cmd.step_idx = step_ff;
      req_stall    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               axis_in     = 1'b0;
               state_in    = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            step_in   = LAST_STEP;
            state_in  = status.bypass ? ST_STORE : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_STORE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            if (!axis_ff) begin
               axis_in  = 1'b1;
               state_in = ST_SETUP;
            end else begin
               state_in = ST_PUBLISH;
            end
         end
         ST_PUBLISH: begin
            // hold until the output register is free
            if (!status.out_busy) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/core/jtdk_dpath.sv
module jtdk_dpath #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  jtdk_pkg::cfg_type      cfg,
   input  jtdk_pkg::cmd_type      cmd,
   output jtdk_pkg::status_type   status,
   input  logic [SAMPLE_BITS-1:0] req_x_sample,
   input  logic [SAMPLE_BITS-1:0] req_y_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [7:0]      rsp_x_percent,
   output logic signed [7:0]      rsp_y_percent,
   output logic                   rsp_axis_valid,
   output logic [2:0]             rsp_x_action,
   output logic [2:0]             rsp_y_action,
   output logic [1:0]             rsp_key_set
);
   import jtdk_pkg::*;

   localparam int W     = SAMPLE_BITS;
   localparam int NUM_W = SAMPLE_BITS + QUOT_BITS;

   function automatic evt_type axis_event(logic signed [7:0] p, logic [THRESH_WIDTH-1:0] t,
                                          logic low, logic high);
      logic signed [8:0] pw;
      logic signed [8:0] tp;
      logic signed [8:0] tn;
      evt_type           r;
      pw       = {p[7], p};
      tp       = $signed({2'b00, t});
      tn       = -tp;
      r.action = ACT_NONE;
      r.low    = low;
      r.high   = high;
      if (!low && pw <= tn) begin
         r.action = ACT_PRESS_LOW;
         r.low    = 1'b1;
      end else if (low && pw > tn) begin
         r.action = ACT_RELEASE_LOW;
         r.low    = 1'b0;
      end else if (!high && pw >= tp) begin
         r.action = ACT_PRESS_HIGH;
         r.high   = 1'b1;
      end else if (high && pw < tp) begin
         r.action = ACT_RELEASE_HIGH;
         r.high   = 1'b0;
      end
      return r;
   endfunction

   // Captured samples
   logic [W-1:0] x_samp_ff, y_samp_ff;

   // Divider state
   logic [NUM_W-1:0]     rem_ff;
   logic [W-1:0]         span_ff;
   logic [QUOT_BITS-1:0] quot_ff;
   logic                 neg_ff;

   // Per-axis percents and held flags
   logic signed [7:0] x_pct_ff, y_pct_ff;
   logic              up_held_ff, down_held_ff, left_held_ff, right_held_ff;

   // Result register
   logic              rsp_valid_ff;
   logic signed [7:0] rsp_x_pct_ff, rsp_y_pct_ff;
   logic              rsp_axis_valid_ff;
   logic [2:0]        rsp_x_act_ff, rsp_y_act_ff;
   logic [1:0]        rsp_key_set_ff;

   // Registers resized to the sample width
   logic [W+CSR_WIDTH-1:0] x_org_wide, y_org_wide, lo_wide, hi_wide;
   logic [W-1:0]           x_org, y_org, lo, hi;

   assign x_org_wide = {{W{1'b0}}, cfg.x_origin};
   assign y_org_wide = {{W{1'b0}}, cfg.y_origin};
   assign lo_wide    = {{W{1'b0}}, cfg.axis_min};
   assign hi_wide    = {{W{1'b0}}, cfg.axis_max};
   assign x_org      = x_org_wide[W-1:0];
   assign y_org      = y_org_wide[W-1:0];
   assign lo         = lo_wide[W-1:0];
   assign hi         = hi_wide[W-1:0];

   // Setup: distance, span and the cases that need no division
   logic [W-1:0]         pos, org, delta, span_mag;
   logic [W:0]           span_w;
   logic                 below, span_neg, span_zero, at_origin, bypass;
   logic [QUOT_BITS-1:0] bypass_mag;
   logic [NUM_W-1:0]     numer;

   always_comb begin
      pos       = cmd.axis ? y_samp_ff : x_samp_ff;
      org       = cmd.axis ? y_org : x_org;
      below     = org > pos;
      delta     = below ? (org - pos) : (pos - org);
      span_w    = below ? ({1'b0, org} - {1'b0, lo}) : ({1'b0, hi} - {1'b0, org});
      span_neg  = span_w[W];
      span_zero = (span_w == '0);
      span_mag  = span_w[W-1:0];
      at_origin = (pos == org);
      numer     = NUM_W'(delta) * NUM_W'(PCT_FULL);
      bypass    = at_origin || span_zero || span_neg || (delta >= span_mag);
      if (at_origin || (span_neg && !span_zero)) begin
         bypass_mag = '0;
      end else begin
         bypass_mag = QUOT_BITS'(PCT_FULL);
      end
   end

   assign status.bypass   = bypass;
   assign status.out_busy = rsp_valid_ff && rsp_stall;

   // One quotient bit per step
   logic [NUM_W-1:0] shifted;
   logic             fits;

   assign shifted = NUM_W'(span_ff) << cmd.step_idx;
   assign fits    = rem_ff >= shifted;

   // Signed percent of the current axis
   logic signed [7:0] mag8, signed_pct;

   assign mag8       = $signed({1'b0, quot_ff});
   assign signed_pct = neg_ff ? -mag8 : mag8;

   // Events for both axes
   evt_type x_evt, y_evt;
   logic    event_mode;

   assign x_evt      = axis_event(x_pct_ff, cfg.threshold, left_held_ff, right_held_ff);
   assign y_evt      = axis_event(y_pct_ff, cfg.threshold, up_held_ff, down_held_ff);
   assign event_mode = cfg.mode inside {MODE_SCROLL, MODE_WASD, MODE_USER};

   // Capture, divide, store and publish
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_samp_ff <= req_x_sample;
         y_samp_ff <= req_y_sample;
      end
      if (cmd.setup) begin
         neg_ff  <= below;
         span_ff <= span_mag;
         rem_ff  <= numer;
         quot_ff <= bypass ? bypass_mag : '0;
      end else if (cmd.div_step && fits) begin
         rem_ff                <= rem_ff - shifted;
         quot_ff[cmd.step_idx] <= 1'b1;
      end
      if (cmd.store) begin
         if (cmd.axis) begin
            y_pct_ff <= signed_pct;
         end else begin
            x_pct_ff <= -signed_pct;
         end
      end
      if (cmd.publish) begin
         rsp_x_pct_ff      <= x_pct_ff;
         rsp_y_pct_ff      <= y_pct_ff;
         rsp_axis_valid_ff <= (cfg.mode == MODE_JOYSTICK);
         rsp_x_act_ff      <= event_mode ? x_evt.action : ACT_NONE;
         rsp_y_act_ff      <= event_mode ? y_evt.action : ACT_NONE;
         rsp_key_set_ff    <= event_mode ? 2'(cfg.mode - MODE_SCROLL) : KEYS_WHEEL;
      end
   end

   // Held flags and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         up_held_ff    <= 1'b0;
         down_held_ff  <= 1'b0;
         left_held_ff  <= 1'b0;
         right_held_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.publish && event_mode) begin
            up_held_ff    <= y_evt.low;
            down_held_ff  <= y_evt.high;
            left_held_ff  <= x_evt.low;
            right_held_ff <= x_evt.high;
         end
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_x_percent  = rsp_x_pct_ff;
   assign rsp_y_percent  = rsp_y_pct_ff;
   assign rsp_axis_valid = rsp_axis_valid_ff;
   assign rsp_x_action   = rsp_x_act_ff;
   assign rsp_y_action   = rsp_y_act_ff;
   assign rsp_key_set    = rsp_key_set_ff;

endmodule

### rtl/core/joystick_to_direction_keys_unit.sv
// Joystick to direction keys.
// Request channel (req_valid / req_stall): one x and one y sample per scan tick.
// Response channel (rsp_valid / rsp_stall): one result beat per request: the
// negated x percent, the y percent, the axis-valid flag, one action per axis
// and the key family.
// Register port (csr_write / csr_index / csr_data): write-only, one register
// per cycle, to be written while the unit is idle; the unit does not enforce it.
// From the accepting edge to rsp_valid, each axis takes a setup step, the
// shared restoring divider (one quotient bit per cycle, skipped when the axis
// is at rest, saturated or its span is negative) and a store step; a publish
// step follows.
// One request is worked on at a time; req_stall is low only when idle.
// A finished response sits in the output register, so the next request is
// taken while rsp_stall holds it; publishing waits only if it is still held.
// Reset (synchronous) loads the register defaults, clears the held flags and
// drops rsp_valid.
module joystick_to_direction_keys_unit #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [SAMPLE_BITS-1:0]                req_x_sample,
   input  logic [SAMPLE_BITS-1:0]                req_y_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [7:0]                     rsp_x_percent,
   output logic signed [7:0]                     rsp_y_percent,
   output logic                                  rsp_axis_valid,
   output logic [2:0]                            rsp_x_action,
   output logic [2:0]                            rsp_y_action,
   output logic [1:0]                            rsp_key_set,
   input  logic                                  csr_write,
   input  logic [jtdk_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [jtdk_pkg::CSR_WIDTH-1:0]        csr_data
);
   import jtdk_pkg::*;

   cfg_type    cfg_ff;
   cmd_type    cmd;
   status_type status;

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_origin  <= ORIGIN_RESET;
         cfg_ff.y_origin  <= ORIGIN_RESET;
         cfg_ff.axis_min  <= AXIS_MIN_RESET;
         cfg_ff.axis_max  <= AXIS_MAX_RESET;
         cfg_ff.threshold <= THRESHOLD_RESET;
         cfg_ff.mode      <= MODE_MOUSE;
      end else if (csr_write) begin
         case (csr_index)
            CSR_X_ORIGIN:  cfg_ff.x_origin  <= csr_data;
            CSR_Y_ORIGIN:  cfg_ff.y_origin  <= csr_data;
            CSR_AXIS_MIN:  cfg_ff.axis_min  <= csr_data;
            CSR_AXIS_MAX:  cfg_ff.axis_max  <= csr_data;
            CSR_THRESHOLD: cfg_ff.threshold <= csr_data[THRESH_WIDTH-1:0];
            CSR_MODE:      cfg_ff.mode      <= csr_data[MODE_WIDTH-1:0];
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   jtdk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   jtdk_dpath #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .cmd            (cmd),
      .status         (status),
      .req_x_sample   (req_x_sample),
      .req_y_sample   (req_y_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_x_percent  (rsp_x_percent),
      .rsp_y_percent  (rsp_y_percent),
      .rsp_axis_valid (rsp_axis_valid),
      .rsp_x_action   (rsp_x_action),
      .rsp_y_action   (rsp_y_action),
      .rsp_key_set    (rsp_key_set)
   );

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import jtdk_pkg::*;

   localparam int SAMPLE_BITS     = 10;
   localparam int SAMPLE_TOP      = (1 << SAMPLE_BITS) - 1;
   localparam int RANDOM_PHASES   = 15;
   localparam int TICKS_PER_PHASE = 125;
   localparam int LONG_HOLD       = 300;
   localparam int SETTLE_CYCLES   = 24;
   localparam int PRINT_LIMIT     = 40;
   localparam int LIMIT_CYCLES    = 600000;

   // Modes without a name in the package
   localparam logic [MODE_WIDTH-1:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [MODE_WIDTH-1:0] MODE_SPARE_LAST  = 3'd7;

   typedef struct {
      logic [SAMPLE_BITS-1:0] x_sample;
      logic [SAMPLE_BITS-1:0] y_sample;
   } tick_type;

   typedef struct {
      logic signed [7:0] x_percent;
      logic signed [7:0] y_percent;
      logic              axis_valid;
      logic [2:0]        x_action;
      logic [2:0]        y_action;
      logic [1:0]        key_set;
   } keys_type;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [SAMPLE_BITS-1:0]   req_x_sample = '0;
   logic [SAMPLE_BITS-1:0]   req_y_sample = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [7:0]        rsp_x_percent;
   logic signed [7:0]        rsp_y_percent;
   logic                     rsp_axis_valid;
   logic [2:0]               rsp_x_action;
   logic [2:0]               rsp_y_action;
   logic [1:0]               rsp_key_set;
   logic                     csr_write = 1'b0;
   logic [CSR_IDX_WIDTH-1:0] csr_index = '0;
   logic [CSR_WIDTH-1:0]     csr_data = '0;

   // Predictor state: register copy and the four held direction flags
   cfg_type cfg_mirror;
   bit      up_held, down_held, left_held, right_held;

   tick_type pending_ticks[$];
   keys_type expected_keys[$];
   int    queued_total   = 0;
   int    accepted_total = 0;
   int    fail_count     = 0;
   int    send_idle_pct  = 0;
   int    recv_stall_pct = 0;
   int    hold_left      = 0;
   logic  hold_arm       = 1'b0;

   joystick_to_direction_keys_unit #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_x_sample   (req_x_sample),
      .req_y_sample   (req_y_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_x_percent  (rsp_x_percent),
      .rsp_y_percent  (rsp_y_percent),
      .rsp_axis_valid (rsp_axis_valid),
      .rsp_x_action   (rsp_x_action),
      .rsp_y_action   (rsp_y_action),
      .rsp_key_set    (rsp_key_set),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Signed deflection of one axis, truncated and saturated at full scale
   function automatic int axis_percent(logic [SAMPLE_BITS-1:0] smp,
                                       logic [CSR_WIDTH-1:0] origin);
      int pos, org, delta, span, sgn, q;
      pos = smp;
      org = origin;
      if (pos == org)
         return 0;
      if (org > pos) begin
         delta = org - pos;
         span  = org - int'(cfg_mirror.axis_min);
         sgn   = -1;
      end else begin
         delta = pos - org;
         span  = int'(cfg_mirror.axis_max) - org;
         sgn   = 1;
      end
      if (span == 0)
         return PCT_FULL * sgn;
      if (span < 0)
         return 0;
      q = (delta * PCT_FULL) / span;
      if (q > PCT_FULL)
         q = PCT_FULL;
      return q * sgn;
   endfunction

   // First matching rule wins: press low, release low, press high, release high
   function automatic logic [2:0] axis_action(int pct, int thr,
                                              inout bit low_held, inout bit high_held);
      if (!low_held && pct <= -thr) begin
         low_held = 1'b1;
         return ACT_PRESS_LOW;
      end
      if (low_held && pct > -thr) begin
         low_held = 1'b0;
         return ACT_RELEASE_LOW;
      end
      if (!high_held && pct >= thr) begin
         high_held = 1'b1;
         return ACT_PRESS_HIGH;
      end
      if (high_held && pct < thr) begin
         high_held = 1'b0;
         return ACT_RELEASE_HIGH;
      end
      return ACT_NONE;
   endfunction

   function automatic void predict_keys(logic [SAMPLE_BITS-1:0] x_smp,
                                        logic [SAMPLE_BITS-1:0] y_smp);
      keys_type r;
      int       xp, yp, thr;
      xp = -axis_percent(x_smp, cfg_mirror.x_origin);
      yp = axis_percent(y_smp, cfg_mirror.y_origin);
      thr = cfg_mirror.threshold;
      r.x_percent  = 8'(xp);
      r.y_percent  = 8'(yp);
      r.axis_valid = 1'b0;
      r.x_action   = ACT_NONE;
      r.y_action   = ACT_NONE;
      r.key_set    = KEYS_WHEEL;
      case (cfg_mirror.mode)
         MODE_SCROLL, MODE_WASD, MODE_USER: begin
            r.y_action = axis_action(yp, thr, up_held, down_held);
            r.x_action = axis_action(xp, thr, left_held, right_held);
            if (cfg_mirror.mode == MODE_SCROLL)
               r.key_set = KEYS_WHEEL;
            else if (cfg_mirror.mode == MODE_WASD)
               r.key_set = KEYS_WASD;
            else
               r.key_set = KEYS_USER;
         end
         MODE_JOYSTICK: begin
            r.axis_valid = 1'b1;
         end
         default: begin
         end
      endcase
      expected_keys.push_back(r);
   endfunction

   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= PRINT_LIMIT)
         $display("%0t ns: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%02h, expected 0x%02h", name, got, want));
   endtask

   // Request driver: hold a beat until taken, then maybe idle before the next
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_keys(req_x_sample, req_y_sample);
            accepted_total++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid    <= 1'b1;
               req_x_sample <= pending_ticks[0].x_sample;
               req_y_sample <= pending_ticks[0].y_sample;
               void'(pending_ticks.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted here
   always @(posedge clock) begin
      if (reset)
         hold_left <= 0;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
      else if (hold_arm)
         hold_left <= LONG_HOLD;
   end

   // Response monitor: compare each taken beat with the oldest expectation
   always @(posedge clock) begin
      keys_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_keys.size() == 0) begin
               report_mismatch("response beat with nothing expected");
            end else begin
               want = expected_keys.pop_front();
               check_field("x_percent", rsp_x_percent, want.x_percent);
               check_field("y_percent", rsp_y_percent, want.y_percent);
               check_field("axis_valid", 8'(rsp_axis_valid), 8'(want.axis_valid));
               check_field("x_action", 8'(rsp_x_action), 8'(want.x_action));
               check_field("y_action", 8'(rsp_y_action), 8'(want.y_action));
               check_field("key_set", 8'(rsp_key_set), 8'(want.key_set));
            end
         end
         rsp_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic write_reg(input logic [CSR_IDX_WIDTH-1:0] idx,
                            input logic [CSR_WIDTH-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      case (idx)
         CSR_X_ORIGIN:  cfg_mirror.x_origin  = value;
         CSR_Y_ORIGIN:  cfg_mirror.y_origin  = value;
         CSR_AXIS_MIN:  cfg_mirror.axis_min  = value;
         CSR_AXIS_MAX:  cfg_mirror.axis_max  = value;
         CSR_THRESHOLD: cfg_mirror.threshold = value[THRESH_WIDTH-1:0];
         CSR_MODE:      cfg_mirror.mode      = value[MODE_WIDTH-1:0];
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   // Write every register; call at a rising edge with the unit idle
   task automatic load_config(input int x_org, input int y_org, input int amin,
                              input int amax, input int thr,
                              input logic [MODE_WIDTH-1:0] md);
      write_reg(CSR_X_ORIGIN, CSR_WIDTH'(x_org));
      write_reg(CSR_Y_ORIGIN, CSR_WIDTH'(y_org));
      write_reg(CSR_AXIS_MIN, CSR_WIDTH'(amin));
      write_reg(CSR_AXIS_MAX, CSR_WIDTH'(amax));
      write_reg(CSR_THRESHOLD, CSR_WIDTH'(thr));
      write_reg(CSR_MODE, CSR_WIDTH'(md));
      csr_write <= 1'b0;
   endtask

   task automatic push_tick(input int x_smp, input int y_smp);
      tick_type t;
      t.x_sample = SAMPLE_BITS'(x_smp);
      t.y_sample = SAMPLE_BITS'(y_smp);
      pending_ticks.push_back(t);
      queued_total++;
   endtask

   // Wait until every queued tick is taken and answered, then let the unit settle
   task automatic drain();
      while (accepted_total != queued_total || expected_keys.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly within the calibrated reach, some at rest, some at the rails, some anywhere
   function automatic int random_sample(logic [CSR_WIDTH-1:0] origin);
      int lo, hi, v, pick;
      lo = cfg_mirror.axis_min;
      hi = cfg_mirror.axis_max;
      if (lo > hi) begin
         lo = cfg_mirror.axis_max;
         hi = cfg_mirror.axis_min;
      end
      pick = $urandom_range(9);
      if (pick < 4)
         v = $urandom_range(hi, lo);
      else if (pick < 6)
         v = int'(origin) + int'($urandom_range(6)) - 3;
      else if (pick == 6)
         v = $urandom_range(1) ? 0 : SAMPLE_TOP;
      else
         v = $urandom_range(SAMPLE_TOP);
      if (v < 0)
         v = 0;
      if (v > SAMPLE_TOP)
         v = SAMPLE_TOP;
      return v;
   endfunction

   // Move the stick out from rest toward a target and back again
   task automatic push_stroke();
      int x0, y0, x1, y1, steps;
      x0 = cfg_mirror.x_origin;
      y0 = cfg_mirror.y_origin;
      x1 = random_sample(cfg_mirror.x_origin);
      y1 = random_sample(cfg_mirror.y_origin);
      steps = $urandom_range(6, 2);
      for (int i = 0; i <= steps; i++)
         push_tick(x0 + (x1 - x0) * i / steps, y0 + (y1 - y0) * i / steps);
      for (int i = steps - 1; i >= 0; i--)
         push_tick(x0 + (x1 - x0) * i / steps, y0 + (y1 - y0) * i / steps);
   endtask

   // Register value: mostly in a usual band, sometimes a rail or anything
   function automatic int pick_reg(int usual_lo, int usual_hi);
      int pick;
      pick = $urandom_range(19);
      if (pick < 2)
         return 0;
      if (pick < 4)
         return SAMPLE_TOP;
      if (pick < 7)
         return $urandom_range(SAMPLE_TOP);
      return $urandom_range(usual_hi, usual_lo);
   endfunction

   task automatic random_config();
      int                    thr, pick;
      logic [MODE_WIDTH-1:0] md;
      pick = $urandom_range(9);
      if (pick == 0)
         thr = $urandom_range(127);
      else if (pick == 1)
         thr = 1;
      else if (pick == 2)
         thr = PCT_FULL;
      else
         thr = $urandom_range(PCT_FULL, 1);
      pick = $urandom_range(19);
      if (pick < 12)
         md = MODE_SCROLL + MODE_WIDTH'(pick % 3);
      else if (pick < 15)
         md = MODE_JOYSTICK;
      else if (pick < 17)
         md = MODE_MOUSE;
      else
         md = MODE_WIDTH'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
      load_config(pick_reg(300, 724), pick_reg(300, 724), pick_reg(0, 200),
                  pick_reg(823, SAMPLE_TOP), thr, md);
   endtask

   initial begin
      int q_mark;
      cfg_mirror.x_origin  = ORIGIN_RESET;
      cfg_mirror.y_origin  = ORIGIN_RESET;
      cfg_mirror.axis_min  = AXIS_MIN_RESET;
      cfg_mirror.axis_max  = AXIS_MAX_RESET;
      cfg_mirror.threshold = THRESHOLD_RESET;
      cfg_mirror.mode      = MODE_MOUSE;
      up_held    = 1'b0;
      down_held  = 1'b0;
      left_held  = 1'b0;
      right_held = 1'b0;
      send_idle_pct  = 12;
      recv_stall_pct = 53;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Mouse mode at defaults: rails, rest, opposite corners
      load_config(512, 512, 0, SAMPLE_TOP, 50, MODE_MOUSE);
      push_tick(0, 0);
      push_tick(SAMPLE_TOP, SAMPLE_TOP);
      push_tick(512, 512);
      push_tick(0, SAMPLE_TOP);
      drain();

      // Scroll: press both directions of x and one of y, then release them
      load_config(512, 512, 0, SAMPLE_TOP, 50, MODE_SCROLL);
      push_tick(0, 0);
      push_tick(SAMPLE_TOP, SAMPLE_TOP);
      push_tick(512, 512);
      push_tick(512, 512);
      drain();

      // WASD: zero span beyond the origin, quotient above full scale, lowest threshold
      load_config(800, 200, 200, 800, 1, MODE_WASD);
      push_tick(800, 200);
      push_tick(900, 100);
      push_tick(801, 199);
      push_tick(0, SAMPLE_TOP);
      push_tick(SAMPLE_TOP, 0);
      drain();

      // User keys: limits on the wrong side of the origin, full-scale threshold
      load_config(512, 512, 600, 400, PCT_FULL, MODE_USER);
      push_tick(0, SAMPLE_TOP);
      push_tick(SAMPLE_TOP, 0);
      push_tick(512, 512);
      drain();

      // Joystick: origins on the rails, truncation to zero
      load_config(0, SAMPLE_TOP, 0, SAMPLE_TOP, PCT_FULL, MODE_JOYSTICK);
      push_tick(SAMPLE_TOP, 0);
      push_tick(0, SAMPLE_TOP);
      push_tick(1, SAMPLE_TOP - 1);
      drain();

      // Unused mode codes with a threshold beyond full scale
      for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++) begin
         load_config(512, 512, 0, SAMPLE_TOP, 127, MODE_WIDTH'(m));
         push_tick(SAMPLE_TOP, 0);
         drain();
      end

      // Scroll with thresholds of zero and beyond full scale
      load_config(512, 512, 0, SAMPLE_TOP, 0, MODE_SCROLL);
      push_tick(512, 512);
      drain();
      load_config(512, 512, 0, SAMPLE_TOP, 127, MODE_SCROLL);
      push_tick(0, SAMPLE_TOP);
      drain();

      // Random phases: strokes with random content plus stray ticks
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p < 5) begin
            send_idle_pct  = 12;
            recv_stall_pct = 53;
         end else if (p < 10) begin
            send_idle_pct  = 53;
            recv_stall_pct = 12;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         random_config();
         for (int n = 0; n < TICKS_PER_PHASE; ) begin
            if ($urandom_range(9) < 7) begin
               q_mark = queued_total;
               push_stroke();
               n += queued_total - q_mark;
            end else begin
               push_tick(random_sample(cfg_mirror.x_origin),
                         random_sample(cfg_mirror.y_origin));
               n++;
            end
         end
         if (p == 2 || p == 11) begin
            hold_arm <= 1'b1;
            @(posedge clock);
            hold_arm <= 1'b0;
         end
         drain();
      end

      if (fail_count == 0 && expected_keys.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #(LIMIT_CYCLES * 12);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

### sim.f
rtl/core/jtdk_pkg.sv
rtl/core/jtdk_ctrl.sv
rtl/core/jtdk_dpath.sv
rtl/core/joystick_to_direction_keys_unit.sv
test/tb_top.sv
